// ===== design/wdst_pkg.sv =====
`default_nettype none

package wdst_pkg;

    localparam logic [1:0] STRIKE_MAX = 2'd3;
    localparam logic [7:0] CNT_MASK   = 8'h30;
    localparam logic [7:0] PHASE_MASK = 8'h0F;
    localparam logic [3:0] PHASE_IDLE = 4'd0;

    typedef enum logic [1:0] {
        CMD_BOOT  = 2'd0,
        CMD_FEED  = 2'd1,
        CMD_CRUMB = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SAFE_STRIKES = 2'd0,
        REG_HEALTHY_TIME = 2'd1,
        REG_RETAINED_TAG = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  safe_mode_strikes;
        logic [31:0] healthy_time_ms;
        logic [1:0]  retained_tag;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic [3:0]  phase;
        logic        watchdog_reset;
        logic        readable;
        logic        write_ok;
    } item_t;

    typedef struct packed {
        logic [7:0]  retained_store;
        logic [31:0] boot_time;
        logic [3:0]  cached_phase;
        logic        cache_valid;
        logic [1:0]  strikes_now;
        logic        safe_flag;
        logic        clear_pending;
        logic        store_usable;
        logic        fail_latch;
    } state_t;

    typedef struct packed {
        logic [1:0] strike_count;
        logic       safe_active;
        logic       crumb_valid;
        logic [3:0] last_phase;
        logic       wdog_cause;
        logic       readable_report;
        logic       writable_report;
        logic       write_error;
        logic       feed_pulse;
        logic [7:0] retained_value;
    } result_t;

    // merge one field, replacing an untagged byte by the bare tag first
    function automatic logic [7:0] field_merge(input logic [7:0] cur, input logic [1:0] tag,
                                               input logic [7:0] mask, input logic [7:0] value);
        logic [7:0] base;
        base = (cur[7:6] == tag) ? cur : {tag, 6'b0};
        return (base & ~mask) | (value & mask);
    endfunction

endpackage

`default_nettype wire

// ===== design/wdst_step.sv =====
`default_nettype none

module wdst_step (
    input  wdst_pkg::cfg_t    cfg,
    input  wdst_pkg::state_t  state,
    input  wdst_pkg::item_t   item,
    output wdst_pkg::state_t  state_next,
    output wdst_pkg::result_t result
);
    import wdst_pkg::*;

    always_comb begin
        state_t     st;
        logic [1:0] strikes;
        logic       valid;
        logic [3:0] prev;
        logic       pulse;
        logic       wr_en;
        logic [31:0] elapsed;

        st      = state;
        strikes = 2'd0;
        valid   = 1'b0;
        prev    = 4'd0;
        pulse   = 1'b0;
        wr_en   = 1'b0;
        elapsed = item.now_ms - state.boot_time;

        case (item.command)
            CMD_BOOT: begin
                st.boot_time     = item.now_ms;
                st.cache_valid   = 1'b0;
                st.cached_phase  = 4'd0;
                st.fail_latch    = 1'b0;
                st.store_usable  = item.readable;
                if (item.readable) begin
                    valid = (st.retained_store[7:6] == cfg.retained_tag);
                    if (valid) begin
                        strikes = st.retained_store[5:4];
                        prev    = st.retained_store[3:0];
                    end else if (item.write_ok) begin
                        st.retained_store = {cfg.retained_tag, 6'b0};
                    end else begin
                        st.store_usable = 1'b0;
                    end
                end
                wr_en = st.store_usable && item.write_ok;
                if (item.watchdog_reset) begin
                    if (strikes != STRIKE_MAX) begin
                        strikes = strikes + 2'd1;
                    end
                    if (wr_en) begin
                        st.retained_store = field_merge(st.retained_store, cfg.retained_tag,
                                                        CNT_MASK, {2'b0, strikes, 4'b0});
                    end
                end else if (strikes != 2'd0) begin
                    strikes = 2'd0;
                    if (wr_en) begin
                        st.retained_store = field_merge(st.retained_store, cfg.retained_tag,
                                                        CNT_MASK, 8'h00);
                    end
                end
                st.strikes_now   = strikes;
                st.safe_flag     = (strikes >= cfg.safe_mode_strikes);
                st.clear_pending = (strikes != 2'd0);
                if (wr_en) begin
                    st.retained_store = field_merge(st.retained_store, cfg.retained_tag,
                                                    PHASE_MASK, {4'b0, PHASE_IDLE});
                    st.cached_phase   = PHASE_IDLE;
                    st.cache_valid    = 1'b1;
                end else begin
                    st.fail_latch = 1'b1;
                end
            end
            CMD_FEED: begin
                wr_en = st.store_usable && item.write_ok;
                if (st.clear_pending && (elapsed >= cfg.healthy_time_ms)) begin
                    st.clear_pending = 1'b0;
                    st.strikes_now   = 2'd0;
                    if (wr_en) begin
                        st.retained_store = field_merge(st.retained_store, cfg.retained_tag,
                                                        CNT_MASK, 8'h00);
                    end
                end
                pulse = 1'b1;
            end
            CMD_CRUMB: begin
                wr_en = st.store_usable && item.write_ok;
                if (!(st.cache_valid && (item.phase == st.cached_phase))) begin
                    if (wr_en) begin
                        st.retained_store = field_merge(st.retained_store, cfg.retained_tag,
                                                        PHASE_MASK, {4'b0, item.phase});
                        st.cached_phase   = item.phase;
                        st.cache_valid    = 1'b1;
                    end else begin
                        st.fail_latch = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        state_next = st;

        result.strike_count    = st.strikes_now;
        result.safe_active     = st.safe_flag;
        result.crumb_valid     = valid;
        result.last_phase      = prev;
        result.wdog_cause      = (item.command == CMD_BOOT) && item.watchdog_reset;
        result.readable_report = (item.command == CMD_BOOT) && item.readable;
        result.writable_report = st.store_usable;
        result.write_error     = st.fail_latch;
        result.feed_pulse      = pulse;
        result.retained_value  = st.retained_store;
    end

endmodule

`default_nettype wire

// ===== design/watchdog_strike_safe_mode_tracker.sv =====
// An accepted input transaction's result is registered and presented on the m_ side.
// Throughput: one transaction per cycle while results drain; the tracker state and the
// result register are updated together by a single pass of the step logic at acceptance.
// s_ready is high whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous) restores the configuration defaults, clears the
// retained byte and all tracker state, and empties the result register.
`default_nettype none

module watchdog_strike_safe_mode_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_now_ms,
    input  wire logic [3:0]  s_phase,
    input  wire logic        s_watchdog_reset,
    input  wire logic        s_readable,
    input  wire logic        s_write_ok,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_strike_count,
    output logic             m_safe_active,
    output logic             m_crumb_valid,
    output logic [3:0]       m_last_phase,
    output logic             m_wdog_cause,
    output logic             m_readable_report,
    output logic             m_writable_report,
    output logic             m_write_error,
    output logic             m_feed_pulse,
    output logic [7:0]       m_retained_value
);
    import wdst_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item;
    result_t result_next;
    result_t result_reg;
    logic    m_valid_reg;
    logic    accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign item.command        = s_command;
    assign item.now_ms         = s_now_ms;
    assign item.phase          = s_phase;
    assign item.watchdog_reset = s_watchdog_reset;
    assign item.readable       = s_readable;
    assign item.write_ok       = s_write_ok;

    wdst_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.safe_mode_strikes <= 2'd3;
            cfg_reg.healthy_time_ms   <= 32'd60000;
            cfg_reg.retained_tag      <= 2'd2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SAFE_STRIKES: cfg_reg.safe_mode_strikes <= cfg_wr_data[1:0];
                REG_HEALTHY_TIME: cfg_reg.healthy_time_ms   <= cfg_wr_data;
                REG_RETAINED_TAG: cfg_reg.retained_tag      <= cfg_wr_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_strike_count    = result_reg.strike_count;
    assign m_safe_active     = result_reg.safe_active;
    assign m_crumb_valid     = result_reg.crumb_valid;
    assign m_last_phase      = result_reg.last_phase;
    assign m_wdog_cause      = result_reg.wdog_cause;
    assign m_readable_report = result_reg.readable_report;
    assign m_writable_report = result_reg.writable_report;
    assign m_write_error     = result_reg.write_error;
    assign m_feed_pulse      = result_reg.feed_pulse;
    assign m_retained_value  = result_reg.retained_value;

    a_feed_no_boot_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_feed_pulse |-> !m_crumb_valid && (m_last_phase == 4'd0)
                                    && !m_wdog_cause && !m_readable_report)
        else $error("feed result carries boot fields");

    a_crumb_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_crumb_valid |-> m_readable_report && m_writable_report)
        else $error("valid crumb reported without readable store");

    a_unreadable_boot: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_command == CMD_BOOT) && !s_readable
        |=> m_valid && !m_writable_report && m_write_error)
        else $error("unreadable boot left store usable");

endmodule

`default_nettype wire
